@@ hw/rtl/dpnf_pkg.sv @@
// Shared types and constants of the dark pixel neighbour filter.
// No dependencies; imported by every module of the block.
package dpnf_pkg;

	// default line buffer depth, overridden from the top level
	localparam int MAX_WIDTH_DEF = 1024;

	// field and register widths
	localparam int PIX_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 12;
	localparam int THR_W      = 4;
	// row counter runs up to image_height + 1 during the drain
	localparam int ROW_W      = 13;
	localparam int WIN_W      = 9;
	localparam int COL_BITS   = 3;

	// front-to-back queue
	localparam int Q_DEPTH = 4;

	// register reset values
	localparam logic [IMG_W_W-1:0] WIDTH_RST    = 11'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RST   = 12'd480;
	localparam logic [THR_W-1:0]   MIN_DARK_RST = 4'd3;

	// output pixel codes
	localparam logic [PIX_W-1:0] PIX_DARK  = 8'd0;
	localparam logic [PIX_W-1:0] PIX_LIGHT = 8'd255;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_MIN_DARK     = 2'd2
	} cfg_reg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [COL_BITS-1:0] column; // bit 0 top, bit 1 middle, bit 2 bottom
		logic                czero;  // item sits in column 0
		logic                emit;   // item produces an output pixel
		logic                last;   // item produces the frame's last output
	} dpnf_op_t;

	// control from front to back
	typedef struct packed {
		logic             restart;  // register write: clear the window
		logic [THR_W-1:0] min_dark; // dark pixels needed in the window
	} dpnf_ctrl_t;

endpackage

@@ hw/rtl/dpnf_front.sv @@
// Front end: configuration registers, raster counters, item classification
// and the two dark-flag line buffers. Depends on dpnf_pkg.
module dpnf_front #(
	parameter int MAX_WIDTH = dpnf_pkg::MAX_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           in_kind,
	input  logic [dpnf_pkg::PIX_W-1:0]     in_pixel,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dpnf_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dpnf_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           op_valid,
	input  logic                           op_ready,
	output dpnf_pkg::dpnf_op_t             op_data,
	output dpnf_pkg::dpnf_ctrl_t           ctrl
);
	import dpnf_pkg::*;

	localparam int CLW = $clog2(MAX_WIDTH);
	localparam int WW  = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;

	logic [IMG_W_W-1:0] width_q;
	logic [IMG_H_W-1:0] height_q;
	logic [THR_W-1:0]   min_dark_q;
	logic               cfg_hit;

	logic [ROW_W-1:0] row_q;
	logic [CLW-1:0]   col_q;

	logic [WW-1:0]      wid_x;
	logic [WW-1:0]      wid_eff;
	logic [ROW_W-1:0]   hgt_eff;
	logic               accept;
	logic               drain;
	logic               ignore;
	logic               acc_work;
	logic               czero;
	logic               ge1;
	logic               ge2;
	logic               emit;
	logic               last;
	logic               dark;
	logic               col_wrap;

	logic           valid_s1;
	logic [CLW-1:0] col_s1;
	logic           dark_s1;
	logic           ge1_s1;
	logic           ge2_s1;
	logic           czero_s1;
	logic           emit_s1;
	logic           last_s1;
	logic           fwd_s1;
	logic [1:0]     fwd_dat_s1;
	logic           s1_go;

	// line buffer entry: bit 1 upper row flag, bit 0 middle row flag
	logic [1:0] line_mem [MAX_WIDTH];
	logic [1:0] rd_q;
	logic [1:0] cur;
	logic [1:0] wr_data;

	// configuration registers; any valid index restarts the frame
	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_IMAGE_WIDTH ||
		cfg_index == CFG_IMAGE_HEIGHT || cfg_index == CFG_MIN_DARK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
			min_dark_q <= MIN_DARK_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_IMAGE_WIDTH:  width_q    <= cfg_data[IMG_W_W-1:0];
				CFG_IMAGE_HEIGHT: height_q   <= cfg_data[IMG_H_W-1:0];
				CFG_MIN_DARK:     min_dark_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign ctrl.restart  = cfg_hit;
	assign ctrl.min_dark = min_dark_q;

	// effective frame size: width clamped to the buffer, zero width or height as one
	always_comb begin
		wid_x = WW'(width_q);
		if (wid_x == '0) begin
			wid_eff = WW'(1);
		end else if (wid_x > WW'(MAX_WIDTH)) begin
			wid_eff = WW'(MAX_WIDTH);
		end else begin
			wid_eff = wid_x;
		end
		hgt_eff = (height_q == '0) ? ROW_W'(1) : ROW_W'(height_q);
	end

	// classify the item at the input
	assign accept   = in_valid && in_ready;
	assign drain    = row_q >= hgt_eff;
	assign ignore   = !drain && in_kind;
	assign acc_work = accept && !ignore;
	assign czero    = col_q == '0;
	assign ge1      = row_q != '0;
	assign ge2      = row_q >= ROW_W'(2);
	assign emit     = czero ? ge2 : ge1;
	assign last     = czero && (row_q == hgt_eff + ROW_W'(1));
	assign dark     = !drain && (in_pixel == '0);
	assign col_wrap = (WW'(col_q) + WW'(1)) == wid_eff;

	// raster position of the next item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (acc_work) begin
			if (last) begin
				row_q <= '0;
				col_q <= '0;
			end else if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CLW'(1);
			end
		end
	end

	// stage 1 waits for the line buffer read
	assign s1_go    = valid_s1 && op_ready;
	assign in_ready = !valid_s1 || op_ready;
	assign op_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_work) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_work) begin
			col_s1     <= col_q;
			dark_s1    <= dark;
			ge1_s1     <= ge1;
			ge2_s1     <= ge2;
			czero_s1   <= czero;
			emit_s1    <= emit;
			last_s1    <= last;
			// same entry written by the item leaving now: take its data
			fwd_s1     <= s1_go && !last_s1 && (col_s1 == col_q);
			fwd_dat_s1 <= wr_data;
		end
	end

	assign cur     = fwd_s1 ? fwd_dat_s1 : rd_q;
	assign wr_data = {cur[0], dark_s1};

	// line buffers: read on accept, shift rows when the item moves on
	always_ff @(posedge clk) begin
		if (acc_work) begin
			rd_q <= line_mem[col_q];
		end
		if (s1_go && !last_s1) begin
			line_mem[col_s1] <= wr_data;
		end
	end

	// masked column for the window
	assign op_data.column = {dark_s1, cur[0] & ge1_s1, cur[1] & ge2_s1};
	assign op_data.czero  = czero_s1;
	assign op_data.emit   = emit_s1;
	assign op_data.last   = last_s1;

endmodule

@@ hw/rtl/dpnf_queue.sv @@
// Short queue of classified items between the front and the back.
// Depends on dpnf_pkg.
module dpnf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  dpnf_pkg::dpnf_op_t push_data,
	output logic               pop_valid,
	input  logic               pop_ready,
	output dpnf_pkg::dpnf_op_t pop_data
);
	import dpnf_pkg::*;

	localparam int AW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	dpnf_op_t      q_mem [Q_DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = cnt_q != CW'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = q_mem[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hw/rtl/dpnf_back.sv @@
// Back end: 3x3 dark window, dark count against the threshold and the
// output register. Depends on dpnf_pkg.
module dpnf_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       op_valid,
	output logic                       op_ready,
	input  dpnf_pkg::dpnf_op_t         op_data,
	input  dpnf_pkg::dpnf_ctrl_t       ctrl,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dpnf_pkg::PIX_W-1:0] out_pixel,
	output logic                       out_last
);
	import dpnf_pkg::*;

	logic [WIN_W-1:0] window_q;
	logic [WIN_W-1:0] win_z;
	logic [WIN_W-1:0] win_c;
	logic [WIN_W-1:0] emit_win;
	logic [WIN_W-1:0] win_n;
	logic [THR_W-1:0] dark_cnt;
	logic             kept;
	logic             out_free;
	logic             pop;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;

	assign out_free = !out_valid_q || out_ready;
	assign op_ready = out_free;
	assign pop      = op_valid && out_free;

	// column 0 first closes the previous row with an empty column
	always_comb begin
		win_z    = {{COL_BITS{1'b0}}, window_q[WIN_W-1:COL_BITS]};
		win_c    = {op_data.column, window_q[WIN_W-1:COL_BITS]};
		emit_win = op_data.czero ? win_z : win_c;
		if (op_data.last) begin
			win_n = '0;
		end else if (op_data.czero) begin
			win_n = {op_data.column, win_z[WIN_W-1:COL_BITS]};
		end else begin
			win_n = win_c;
		end
		dark_cnt = THR_W'($countones(emit_win));
		kept     = emit_win[4] && (dark_cnt >= ctrl.min_dark);
	end

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (ctrl.restart) begin
			window_q <= '0;
		end else if (pop) begin
			window_q <= win_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && op_data.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && op_data.emit) begin
			out_pixel_q <= kept ? PIX_DARK : PIX_LIGHT;
			out_last_q  <= op_data.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;

endmodule

@@ hw/rtl/dark_pixel_neighbour_filter.sv @@
// Top level of the dark pixel neighbour filter: front, queue and back.
// Depends on dpnf_pkg, dpnf_front, dpnf_queue and dpnf_back.
//
// Usage:
//   s_axis carries one item per handshake: tdata is the gray pixel, tuser
//   is the kind (0 pixel, 1 flush). Pixels come in raster order; after the
//   last pixel of a frame, image_width + 1 further items (flush or pixel)
//   drain the pending outputs. A flush while pixels are still expected is
//   taken and dropped.
//   m_axis returns filtered pixels (0 kept dark, 255 otherwise); tlast marks
//   the frame's last output, after which a new frame begins.
//   cfg writes register index cfg_index with cfg_data; cfg_ready is always
//   high. Write only while the block is idle; a write to a defined index restarts the frame.
// Throughput: one item per cycle while the receiver is ready, with the line
//   buffer read on accept and the window updated in the back end as items are taken.
// Output path: the output for a pixel is carried by the item image_width + 1
//   positions later and passes through stage 1, the queue and the output
//   register before it appears on m_axis, when the receiver is ready.
// Stall: a stalled receiver holds the output register; the four-entry queue
//   and stage 1 keep taking items until they are full, then s_axis_tready
//   drops. Reset clears counters, window and queue; line buffers need no
//   clearing since unwritten entries are masked by the row counter.
module dark_pixel_neighbour_filter #(
	parameter int MAX_WIDTH = dpnf_pkg::MAX_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dpnf_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel_in
	input  logic                            s_axis_tuser,  // [0] kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dpnf_pkg::PIX_W-1:0]      m_axis_tdata,  // [7:0] pixel_out
	output logic                            m_axis_tlast,  // frame_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dpnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dpnf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpnf_pkg::*;

	logic       f_valid;
	logic       f_ready;
	dpnf_op_t   f_data;
	logic       b_valid;
	logic       b_ready;
	dpnf_op_t   b_data;
	dpnf_ctrl_t ctrl;

	// classification and line buffers
	dpnf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_pixel  (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op_valid  (f_valid),
		.op_ready  (f_ready),
		.op_data   (f_data),
		.ctrl      (ctrl)
	);

	// decoupling queue
	dpnf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_data)
	);

	// window and output
	dpnf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (b_valid),
		.op_ready  (b_ready),
		.op_data   (b_data),
		.ctrl      (ctrl),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pixel (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ hw/rtl/dpnf_checker.sv @@
// Port-level checks of the dark pixel neighbour filter, bound to its top.
// Depends on dpnf_pkg and dark_pixel_neighbour_filter.
module dpnf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic [dpnf_pkg::PIX_W-1:0]      s_axis_tdata,
	input logic                            s_axis_tuser,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dpnf_pkg::PIX_W-1:0]      m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [dpnf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [dpnf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dpnf_pkg::*;

	// a stalled output item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	// output pixels are binary
	a_out_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata == PIX_DARK || m_axis_tdata == PIX_LIGHT))
		else $error("output pixel is neither dark nor light");

	// register writes are never back-pressured
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// no output once reset has been seen at an edge
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind dark_pixel_neighbour_filter dpnf_checker u_dpnf_checker (.*);
